@@ src/aes_pkg.sv @@
// Package: AES tables, field helpers, register indexes and shared types.
`timescale 1ns / 1ps
package aes_pkg;

   localparam int BLOCK_W = 128;
   localparam int HALF_W  = 64;
   localparam int WORD_W  = 32;

   localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] REG_KEY_SIZE   = 3'd4;
   localparam logic [2:0] REG_DIRECTION  = 3'd5;

   localparam logic [1:0] SIZE_128 = 2'd0;
   localparam logic [1:0] SIZE_192 = 2'd1;
   localparam logic [1:0] SIZE_256 = 2'd2;

   typedef struct packed {
      logic active;
      logic last;
      logic decrypt;
   } round_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

@@ src/aes_if.sv @@
// Interfaces: request and response channels of the cipher.
`timescale 1ns / 1ps
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, output block_high, output block_low, input ready);
   modport sink (input valid, input block_high, input block_low, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, output result_high, output result_low, input ready);
   modport sink (input valid, input result_high, input result_low, output ready);
endinterface

@@ src/aes_block_cipher_top.sv @@
// Top level: key schedule sequencer and fully unrolled AES round pipeline.
// A block enters stage register st_ff[0] and leaves from st_ff[MAX_ROUNDS] at result transfer.
// Throughput: one block per cycle; the whole pipeline holds while a result waits.
// Key expansion runs after reset or a key/key-size write: a restart step, then one schedule
// word per cycle; no request transfer is taken meanwhile.
// Reset: synchronous, active high; clears the key, control and valid registers and expands the zero key.
`timescale 1ns / 1ps
module aes_block_cipher_top
   import aes_pkg::*;
#(
   parameter int SCHEDULE_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   aes_req_if.sink     req,
   aes_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int MAX_ROUNDS = SCHEDULE_WORDS / 4 - 1;
   localparam int IDX_W = $clog2(SCHEDULE_WORDS);
   localparam int CNT_W = $clog2(SCHEDULE_WORDS + 1);

   logic [63:0] key_word_ff [4];
   logic [1:0]  key_size_ff;
   logic        direction_ff;
   logic        restart_ff;
   logic        busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [2:0]  mod_ff;
   logic [7:0]  rc_ff;
   logic [31:0] win_ff [8];
   logic [1:0]  sz_ff;
   logic [31:0] rk_ff [SCHEDULE_WORDS];

   logic [1:0]  sz_in;
   logic [3:0]  nk;
   logic [3:0]  nr;
   logic [CNT_W-1:0] total;
   logic [31:0] new_word;
   logic [31:0] t_word;
   logic [31:0] old_word;
   logic [63:0] kreg;

   always_comb begin
      sz_in = (key_size_ff > SIZE_256) ? SIZE_256 : key_size_ff;
      if (sz_in == SIZE_256 && SCHEDULE_WORDS < 60) sz_in = SIZE_192;
      if (sz_in == SIZE_192 && SCHEDULE_WORDS < 52) sz_in = SIZE_128;
   end

   assign nk    = 4'd4 + {1'b0, sz_ff, 1'b0};
   assign nr    = nk + 4'd6;
   assign total = CNT_W'({nr, 2'b00} + 6'd4);

   always_comb begin
      kreg   = key_word_ff[cnt_ff[2:1]];
      t_word = win_ff[0];
      unique case (nk)
         4'd4:    old_word = win_ff[3];
         4'd6:    old_word = win_ff[5];
         default: old_word = win_ff[7];
      endcase
      if (mod_ff == 3'd0) begin
         t_word = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rc_ff, 24'h0};
      end else if (nk == 4'd8 && mod_ff == 3'd4) begin
         t_word = sub_word(win_ff[0]);
      end
      if (cnt_ff < CNT_W'(nk)) begin
         new_word = cnt_ff[0] ? kreg[31:0] : kreg[63:32];
      end else begin
         new_word = old_word ^ t_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_word_ff[i] <= '0;
         key_size_ff  <= SIZE_128;
         direction_ff <= 1'b0;
         restart_ff   <= 1'b1;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         mod_ff       <= '0;
         rc_ff        <= 8'h01;
         sz_ff        <= SIZE_128;
      end else begin
         restart_ff <= csr_wr_en && (csr_index <= REG_KEY_SIZE);
         if (csr_wr_en) begin
            unique case (csr_index) inside
               REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
                  key_word_ff[csr_index[1:0]] <= csr_wr_data;
               end
               REG_KEY_SIZE: key_size_ff <= csr_wr_data[1:0];
               REG_DIRECTION: direction_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (restart_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            mod_ff  <= '0;
            rc_ff   <= 8'h01;
            sz_ff   <= sz_in;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            mod_ff <= (mod_ff == 3'(nk - 4'd1)) ? 3'd0 : mod_ff + 3'd1;
            if (mod_ff == 3'd0 && cnt_ff >= CNT_W'(nk)) rc_ff <= xtime(rc_ff);
            if (cnt_ff == total - 1'b1) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !restart_ff) begin
         rk_ff[cnt_ff[IDX_W-1:0]] <= new_word;
         win_ff[0] <= new_word;
         for (int i = 1; i < 8; i++) win_ff[i] <= win_ff[i-1];
      end
   end

   function automatic logic [127:0] rk_blk(input int rnd);
      if (rnd >= 0 && 4 * rnd + 3 < SCHEDULE_WORDS) begin
         return {rk_ff[IDX_W'(4 * rnd)], rk_ff[IDX_W'(4 * rnd + 1)],
                 rk_ff[IDX_W'(4 * rnd + 2)], rk_ff[IDX_W'(4 * rnd + 3)]};
      end
      return '0;
   endfunction

   logic [127:0] st_ff [MAX_ROUNDS + 1];
   logic [127:0] st_in [MAX_ROUNDS + 1];
   logic [127:0] key_sel [MAX_ROUNDS + 1];
   logic [MAX_ROUNDS:0] vld_ff;
   logic advance;

   assign advance   = !vld_ff[MAX_ROUNDS] || rsp.ready;
   assign req.ready = advance && !busy_ff && !restart_ff;

   for (genvar j = 0; j <= MAX_ROUNDS; j++) begin : g_stage
      always_comb begin
         if (direction_ff) begin
            unique case (sz_ff)
               SIZE_128: key_sel[j] = rk_blk(10 - j);
               SIZE_192: key_sel[j] = rk_blk(12 - j);
               default:  key_sel[j] = rk_blk(14 - j);
            endcase
         end else begin
            key_sel[j] = rk_blk(j);
         end
      end
      if (j == 0) begin : g_first
         assign st_in[0] = {req.block_high, req.block_low} ^ key_sel[0];
      end else begin : g_round
         round_ctl_type ctl;
         assign ctl.active  = 4'(j) <= nr;
         assign ctl.last    = 4'(j) == nr;
         assign ctl.decrypt = direction_ff;
         aes_round u_round (
            .st_in     (st_ff[j-1]),
            .round_key (key_sel[j]),
            .ctl       (ctl),
            .st_out    (st_in[j])
         );
      end
      always_ff @(posedge clock) begin
         if (advance) st_ff[j] <= st_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[MAX_ROUNDS-1:0], req.valid && req.ready};
      end
   end

   assign rsp.valid       = vld_ff[MAX_ROUNDS];
   assign rsp.result_high = st_ff[MAX_ROUNDS][127:64];
   assign rsp.result_low  = st_ff[MAX_ROUNDS][63:0];

endmodule

@@ src/aes_round.sv @@
// One cipher round, forward or inverse, with pass-through for unused rounds.
`timescale 1ns / 1ps
module aes_round
   import aes_pkg::*;
(
   input  logic [127:0]  st_in,
   input  logic [127:0]  round_key,
   input  round_ctl_type ctl,
   output logic [127:0]  st_out
);

   function automatic logic [7:0] mul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] a2;
      logic [7:0] a4;
      logic [7:0] a8;
      a2 = xtime(a);
      a4 = xtime(a2);
      a8 = xtime(a4);
      return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^
             (m[3] ? a8 : 8'h00);
   endfunction

   logic [7:0] s_in [16];
   logic [7:0] sub [16];
   logic [7:0] shf [16];
   logic [7:0] mix [16];
   logic [127:0] pre_mix;
   logic [127:0] post_mix;
   logic [3:0] mc [4];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         s_in[k] = st_in[127 - 8 * k -: 8];
         sub[k]  = ctl.decrypt ? INV_SBOX[s_in[k]] : SBOX[s_in[k]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctl.decrypt) begin
               shf[r + 4 * ((c + r) % 4)] = sub[r + 4 * c];
            end else begin
               shf[r + 4 * c] = sub[r + 4 * ((c + r) % 4)];
            end
         end
      end
      for (int k = 0; k < 16; k++) begin
         pre_mix[127 - 8 * k -: 8] = shf[k];
      end
      if (ctl.decrypt) begin
         pre_mix = pre_mix ^ round_key;
         mc[0] = 4'he; mc[1] = 4'hb; mc[2] = 4'hd; mc[3] = 4'h9;
      end else begin
         mc[0] = 4'h2; mc[1] = 4'h3; mc[2] = 4'h1; mc[3] = 4'h1;
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            mix[4 * c + r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
               mix[4 * c + r] = mix[4 * c + r] ^
                  mul(pre_mix[127 - 8 * (4 * c + k) -: 8], mc[(k - r + 4) % 4]);
            end
         end
      end
      for (int k = 0; k < 16; k++) begin
         post_mix[127 - 8 * k -: 8] = ctl.last ? pre_mix[127 - 8 * k -: 8] : mix[k];
      end
      if (!ctl.active) begin
         st_out = st_in;
      end else if (ctl.decrypt) begin
         st_out = post_mix;
      end else begin
         st_out = post_mix ^ round_key;
      end
   end

endmodule
